@@ design/tbgc_pkg.sv @@
// shared types, widths and codes for the two-button gesture classifier
package tbgc_pkg;

	// hold counter width
	localparam int HOLD_BITS = 8;
	// configuration register width
	localparam int CFG_BITS = 8;
	// press tally width and saturation value
	localparam int TALLY_BITS = 3;
	localparam logic [TALLY_BITS-1:0] TALLY_MAX = 3'd4;

	// most events one tick can cause
	localparam int MAX_EV = 4;
	// event queue geometry
	localparam int EQ_DEPTH = 8;
	localparam int EQ_AW = 3;

	typedef logic [HOLD_BITS-1:0] hold_t;
	typedef logic [HOLD_BITS:0] hold_ext_t;
	typedef logic [CFG_BITS-1:0] cfg_val_t;
	typedef logic [TALLY_BITS-1:0] tally_t;
	typedef logic [2:0] ev_cnt_t;
	typedef logic [EQ_AW-1:0] eq_ptr_t;
	typedef logic [EQ_AW:0] eq_fill_t;

	// gesture codes
	localparam logic [2:0] G_SINGLE = 3'd0;
	localparam logic [2:0] G_DOUBLE = 3'd1;
	localparam logic [2:0] G_TRIPLE = 3'd2;
	localparam logic [2:0] G_LONG = 3'd3;
	localparam logic [2:0] G_REPEAT = 3'd4;

	// button codes
	localparam logic BTN_RIGHT = 1'b0;
	localparam logic BTN_LEFT = 1'b1;

	// configuration register indexes
	localparam logic [1:0] CFG_LONG_HOLD = 2'd0;
	localparam logic [1:0] CFG_SHORT_HOLD = 2'd1;
	localparam logic [1:0] CFG_MULTI_WIN = 2'd2;

	typedef struct packed {
		cfg_val_t long_hold;
		cfg_val_t short_hold;
		cfg_val_t multi_win;
	} cfg_t;

	typedef struct packed {
		logic btn;
		logic [2:0] gest;
		logic last;
	} event_t;

endpackage

@@ design/two_button_gesture_classifier.sv @@
// top level of the two-button gesture classifier
// One input transaction is one 5 ms tick carrying both button levels and push
// edges. Hold counting, multi-press window expiry and push counting all happen
// in one registered pass over the tick, and the zero to four events the tick
// causes are written together into an eight-entry event queue. Events leave
// one per output transaction, right or left button with a gesture code, and
// last_of_tick marks the final event of each tick. in_ready is high whenever
// the queue has room for four more events, so a tick can be taken every cycle
// while the consumer keeps up; with the output always ready the sustained tick
// rate is set by the single output port of the event queue.
// Configuration registers (long hold, short hold, multi-press window, in ticks)
// are written through cfg_we / cfg_index / cfg_data; the user must write them
// only while no tick is in flight, which the block itself does not enforce;
// index 3 is ignored.
module two_button_gesture_classifier (
	input logic clk,
	input logic arst_n,
	// configuration write port
	input logic cfg_we,
	input logic [1:0] cfg_index,
	input logic [tbgc_pkg::CFG_BITS-1:0] cfg_data,
	// tick input
	input logic in_valid,
	output logic in_ready,
	input logic right_level,
	input logic left_level,
	input logic right_push,
	input logic left_push,
	// event output
	output logic out_valid,
	input logic out_ready,
	output logic which_button,
	output logic [2:0] gesture,
	output logic last_of_tick
);

	tbgc_pkg::cfg_t cfg_q;
	logic in_accept;
	logic out_accept;
	tbgc_pkg::event_t [tbgc_pkg::MAX_EV-1:0] tick_events;
	tbgc_pkg::ev_cnt_t tick_count;
	tbgc_pkg::event_t head_event;
	tbgc_pkg::eq_fill_t fill;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_hold <= 8'd200;
			cfg_q.short_hold <= 8'd120;
			cfg_q.multi_win <= 8'd120;
		end else if (cfg_we) begin
			unique case (cfg_index)
				tbgc_pkg::CFG_LONG_HOLD: cfg_q.long_hold <= cfg_data;
				tbgc_pkg::CFG_SHORT_HOLD: cfg_q.short_hold <= cfg_data;
				tbgc_pkg::CFG_MULTI_WIN: cfg_q.multi_win <= cfg_data;
				default: ;
			endcase
		end
	end

	// room for a full tick's worth of events
	assign in_ready = (fill <= tbgc_pkg::eq_fill_t'(tbgc_pkg::EQ_DEPTH - tbgc_pkg::MAX_EV));
	assign in_accept = in_valid && in_ready;

	// gesture state and per-tick event batch
	tbgc_tick u_tick (
		.clk (clk),
		.arst_n (arst_n),
		.cfg (cfg_q),
		.accept (in_accept),
		.right_level (right_level),
		.left_level (left_level),
		.right_push (right_push),
		.left_push (left_push),
		.events (tick_events),
		.event_count (tick_count)
	);

	// events wait here until the consumer takes them
	assign out_valid = (fill != '0);
	assign out_accept = out_valid && out_ready;

	tbgc_evq u_evq (
		.clk (clk),
		.arst_n (arst_n),
		.wr_en (in_accept),
		.wr_events (tick_events),
		.wr_count (tick_count),
		.rd_en (out_accept),
		.rd_event (head_event),
		.fill (fill)
	);

	assign which_button = head_event.btn;
	assign gesture = head_event.gest;
	assign last_of_tick = head_event.last;

`ifndef SYNTH
	// queue never overfills
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill <= tbgc_pkg::eq_fill_t'(tbgc_pkg::EQ_DEPTH))
		else $error("event queue overfilled");

	// ticks are written whole, so the newest queued event always closes its tick
	a_last_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && fill == tbgc_pkg::eq_fill_t'(1)) |-> last_of_tick)
		else $error("lone queued event does not close its tick");

	// only defined gesture codes leave the block
	a_gesture_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (gesture <= tbgc_pkg::G_REPEAT))
		else $error("undefined gesture code");

	// a tick taken into an empty queue with no events leaves it empty
	a_empty_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(in_accept && tick_count == '0 && fill == '0) |=> (fill == '0))
		else $error("tick with no events changed queue fill");
`endif

endmodule

@@ design/tbgc_tick.sv @@
// per-tick gesture state and event generation
module tbgc_tick (
	input logic clk,
	input logic arst_n,
	input tbgc_pkg::cfg_t cfg,
	input logic accept,
	input logic right_level,
	input logic left_level,
	input logic right_push,
	input logic left_push,
	output tbgc_pkg::event_t [tbgc_pkg::MAX_EV-1:0] events,
	output tbgc_pkg::ev_cnt_t event_count
);

	typedef struct packed {
		tbgc_pkg::hold_t h;
		logic la;
		tbgc_pkg::tally_t t;
		logic fire;
		logic [2:0] gest;
	} step_t;

	tbgc_pkg::hold_t hold_q [2];
	logic long_q [2];
	tbgc_pkg::tally_t tally_q [2];
	tbgc_pkg::cfg_val_t win_rem_q;
	logic win_run_q;

	tbgc_pkg::hold_t h_n [2];
	logic la_n [2];
	tbgc_pkg::tally_t t_n [2];
	tbgc_pkg::cfg_val_t rem_n;
	logic run_n;

	tbgc_pkg::event_t cand [tbgc_pkg::MAX_EV];
	logic cand_v [tbgc_pkg::MAX_EV];
	tbgc_pkg::ev_cnt_t pos [tbgc_pkg::MAX_EV];

	function automatic step_t hold_step(input tbgc_pkg::hold_t h, input logic la,
		input tbgc_pkg::tally_t t, input tbgc_pkg::cfg_val_t lim);
		step_t r;
		tbgc_pkg::hold_t h1;
		h1 = h + 1'b1;
		r.h = h1;
		r.la = la;
		r.t = t;
		r.fire = 1'b0;
		r.gest = tbgc_pkg::G_LONG;
		if (h1 >= tbgc_pkg::hold_t'(lim)) begin
			r.h = h1 - tbgc_pkg::hold_t'(lim);
			r.fire = 1'b1;
			r.gest = la ? tbgc_pkg::G_REPEAT : tbgc_pkg::G_LONG;
			r.la = 1'b1;
			r.t = '0;
		end
		return r;
	endfunction

	always_comb begin
		step_t sr;
		step_t sl;
		tbgc_pkg::hold_ext_t hx;
		for (int b = 0; b < 2; b++) begin
			h_n[b] = hold_q[b];
			la_n[b] = long_q[b];
			t_n[b] = tally_q[b];
		end
		rem_n = win_rem_q;
		run_n = win_run_q;
		for (int i = 0; i < tbgc_pkg::MAX_EV; i++) begin
			cand[i] = '0;
			cand_v[i] = 1'b0;
		end

		// hold phase fills slots 0 and 1
		sr = hold_step(hold_q[0], long_q[0], tally_q[0], cfg.long_hold);
		sl = hold_step(hold_q[1], long_q[1], tally_q[1], cfg.long_hold);
		if (right_level && left_level) begin
			h_n[1] = sl.h; la_n[1] = sl.la; t_n[1] = sl.t;
			cand_v[0] = sl.fire;
			cand[0].btn = tbgc_pkg::BTN_LEFT;
			cand[0].gest = sl.gest;
			h_n[0] = sr.h; la_n[0] = sr.la; t_n[0] = sr.t;
			cand_v[1] = sr.fire;
			cand[1].btn = tbgc_pkg::BTN_RIGHT;
			cand[1].gest = sr.gest;
		end else if (right_level) begin
			h_n[0] = sr.h; la_n[0] = sr.la; t_n[0] = sr.t;
			cand_v[0] = sr.fire;
			cand[0].btn = tbgc_pkg::BTN_RIGHT;
			cand[0].gest = sr.gest;
			h_n[1] = '0;
		end else if (left_level) begin
			h_n[1] = sl.h; la_n[1] = sl.la; t_n[1] = sl.t;
			cand_v[0] = sl.fire;
			cand[0].btn = tbgc_pkg::BTN_LEFT;
			cand[0].gest = sl.gest;
			h_n[0] = '0;
		end else begin
			// release: right in slot 0, left in slot 1
			for (int b = 0; b < 2; b++) begin
				cand[b].btn = b[0];
				cand[b].gest = tbgc_pkg::G_SINGLE;
				if (long_q[b]) begin
					la_n[b] = 1'b0;
				end else if (hold_q[b] >= tbgc_pkg::hold_t'(cfg.short_hold)) begin
					cand_v[b] = 1'b1;
				end
				h_n[b] = '0;
			end
		end

		// window expiry fills slots 2 (right) and 3 (left)
		if (win_run_q) begin
			if (win_rem_q <= 8'd1) begin
				rem_n = '0;
				run_n = 1'b0;
				for (int b = 0; b < 2; b++) begin
					hx = {1'b0, h_n[b]} + 1'b1;
					cand[2 + b].btn = b[0];
					if (!la_n[b] && hx < tbgc_pkg::hold_ext_t'(cfg.short_hold)) begin
						case (t_n[b])
							3'd1: begin
								cand_v[2 + b] = 1'b1;
								cand[2 + b].gest = tbgc_pkg::G_SINGLE;
							end
							3'd2: begin
								cand_v[2 + b] = 1'b1;
								cand[2 + b].gest = tbgc_pkg::G_DOUBLE;
							end
							3'd3: begin
								cand_v[2 + b] = 1'b1;
								cand[2 + b].gest = tbgc_pkg::G_TRIPLE;
							end
							default: ;
						endcase
						t_n[b] = '0;
					end
				end
			end else begin
				rem_n = win_rem_q - 1'b1;
			end
		end

		// push counting
		if (right_push) begin
			if (t_n[0] < tbgc_pkg::TALLY_MAX) t_n[0] = t_n[0] + 1'b1;
			rem_n = cfg.multi_win;
			run_n = 1'b1;
		end
		if (left_push) begin
			if (t_n[1] < tbgc_pkg::TALLY_MAX) t_n[1] = t_n[1] + 1'b1;
			rem_n = cfg.multi_win;
			run_n = 1'b1;
		end
	end

	// pack the fired slots in order and mark the final one
	always_comb begin
		tbgc_pkg::ev_cnt_t acc;
		acc = '0;
		for (int i = 0; i < tbgc_pkg::MAX_EV; i++) begin
			pos[i] = acc;
			acc = acc + tbgc_pkg::ev_cnt_t'(cand_v[i]);
		end
		event_count = acc;
		for (int j = 0; j < tbgc_pkg::MAX_EV; j++) begin
			events[j] = '0;
			for (int i = 0; i < tbgc_pkg::MAX_EV; i++) begin
				if (cand_v[i] && pos[i] == tbgc_pkg::ev_cnt_t'(j)) begin
					events[j] = cand[i];
				end
			end
			events[j].last = (tbgc_pkg::ev_cnt_t'(j) == acc - 1'b1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 2; b++) begin
				hold_q[b] <= '0;
				long_q[b] <= 1'b0;
				tally_q[b] <= '0;
			end
			win_rem_q <= '0;
			win_run_q <= 1'b0;
		end else if (accept) begin
			for (int b = 0; b < 2; b++) begin
				hold_q[b] <= h_n[b];
				long_q[b] <= la_n[b];
				tally_q[b] <= t_n[b];
			end
			win_rem_q <= rem_n;
			win_run_q <= run_n;
		end
	end

endmodule

@@ design/tbgc_evq.sv @@
// event queue: takes a batch of up to four events, hands out one per transaction
module tbgc_evq (
	input logic clk,
	input logic arst_n,
	input logic wr_en,
	input tbgc_pkg::event_t [tbgc_pkg::MAX_EV-1:0] wr_events,
	input tbgc_pkg::ev_cnt_t wr_count,
	input logic rd_en,
	output tbgc_pkg::event_t rd_event,
	output tbgc_pkg::eq_fill_t fill
);

	tbgc_pkg::event_t mem_q [tbgc_pkg::EQ_DEPTH];
	tbgc_pkg::eq_ptr_t head_q;
	tbgc_pkg::eq_ptr_t tail_q;
	tbgc_pkg::eq_fill_t fill_q;
	tbgc_pkg::ev_cnt_t n_wr;

	assign n_wr = wr_en ? wr_count : '0;
	assign rd_event = mem_q[head_q];
	assign fill = fill_q;

	always_ff @(posedge clk) begin
		for (int k = 0; k < tbgc_pkg::MAX_EV; k++) begin
			if (tbgc_pkg::ev_cnt_t'(k) < n_wr) begin
				mem_q[tail_q + tbgc_pkg::eq_ptr_t'(k)] <= wr_events[k];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			tail_q <= '0;
			fill_q <= '0;
		end else begin
			tail_q <= tail_q + tbgc_pkg::eq_ptr_t'(n_wr);
			if (rd_en) head_q <= head_q + 1'b1;
			fill_q <= fill_q + tbgc_pkg::eq_fill_t'(n_wr) - tbgc_pkg::eq_fill_t'(rd_en);
		end
	end

endmodule
